### rtl/imu_tilt_complementary_filter_macros.svh
// Assertion macros for the tilt filter
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### rtl/imutcf_pkg.sv
// Shared types, constants and tables of the tilt filter
package imutcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN = 24;
    localparam int XW = 33;
    localparam int ZW = 26;

    localparam logic REG_BLEND = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    localparam logic [16:0] BLEND_RESET = 17'd64225;
    localparam logic [15:0] GAIN_RESET = 16'd5114;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic signed [21:0] ANGLE_LIMIT = 22'sd46080;
    localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] step);
        logic signed [ZW-1:0] v;
        case (step)
            5'd0: v = 26'sd2949120;
            5'd1: v = 26'sd1740967;
            5'd2: v = 26'sd919879;
            5'd3: v = 26'sd466945;
            5'd4: v = 26'sd234379;
            5'd5: v = 26'sd117304;
            5'd6: v = 26'sd58666;
            5'd7: v = 26'sd29335;
            5'd8: v = 26'sd14668;
            5'd9: v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    function automatic cord_t cordic_init(input logic signed [15:0] num,
                                          input logic signed [15:0] den);
        cord_t c;
        c.x = {{3{den[15]}}, den, 14'b0};
        c.y = {{3{num[15]}}, num, 14'b0};
        c.z = '0;
        if (den[15])
        begin
            c.x = -c.x;
            c.y = -c.y;
            c.z = num[15] ? -HALF_TURN : HALF_TURN;
        end
        return c;
    endfunction

endpackage

### rtl/imutcf_cordic_cell.sv
// One vectoring CORDIC iteration cell of the chain
module imutcf_cordic_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  imutcf_pkg::cord_t    d_in,
    input  logic [4:0]           step,
    output logic                 valid_out,
    output imutcf_pkg::cord_t    d_out
);

    logic              valid_reg;
    imutcf_pkg::cord_t d_reg;
    imutcf_pkg::cord_t d_next;

    always_comb
    begin
        d_next = d_in;
        if (!d_in.y[imutcf_pkg::XW-1])
        begin
            d_next.x = d_in.x + (d_in.y >>> step);
            d_next.y = d_in.y - (d_in.x >>> step);
            d_next.z = d_in.z + imutcf_pkg::atan_val(step);
        end
        else
        begin
            d_next.x = d_in.x - (d_in.y >>> step);
            d_next.y = d_in.y + (d_in.x >>> step);
            d_next.z = d_in.z - imutcf_pkg::atan_val(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
            d_reg <= d_next;
    end

    assign valid_out = valid_reg;
    assign d_out = d_reg;

endmodule

### rtl/imutcf_blend.sv
// Weighted blend of gyro and accelerometer angle with rounding and saturation
module imutcf_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic                                take,
    input  logic signed [imutcf_pkg::ZW-1:0]    acc,
    input  logic                                zero,
    input  logic signed [16:0]                  prev,
    input  logic signed [15:0]                  gyro,
    input  logic [15:0]                         gain,
    input  logic [16:0]                         weight,
    output logic                                res_valid,
    output logic signed [16:0]                  res
);

    logic                             v1_reg, v2_reg, v3_reg;
    logic signed [32:0]               gg_reg;
    logic signed [imutcf_pkg::ZW-1:0] acc1_reg, acc2_reg, acc3_reg;
    logic [16:0]                      a1_reg, a2_reg;
    logic signed [35:0]               d_reg;
    logic [34:0]                      plo_reg;
    logic signed [35:0]               phi_reg;
    logic signed [53:0]               t;
    logic signed [21:0]               r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg | (v3_reg & ~take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            gg_reg <= gyro * $signed({1'b0, gain});
            acc1_reg <= zero ? '0 : acc;
            a1_reg <= (weight > imutcf_pkg::WEIGHT_ONE) ? imutcf_pkg::WEIGHT_ONE : weight;
        end
        if (v1_reg)
        begin
            d_reg <= ({{3{prev[16]}}, prev, 16'b0}) + 36'(gg_reg)
                   - ({{2{acc1_reg[imutcf_pkg::ZW-1]}}, acc1_reg, 8'b0});
            acc2_reg <= acc1_reg;
            a2_reg <= a1_reg;
        end
        if (v2_reg)
        begin
            plo_reg <= a2_reg * d_reg[17:0];
            phi_reg <= $signed({1'b0, a2_reg}) * $signed(d_reg[35:18]);
            acc3_reg <= acc2_reg;
        end
    end

    always_comb
    begin
        t = (54'(phi_reg) <<< 18) + $signed({19'b0, plo_reg})
          + (54'(acc3_reg) <<< 24) + $signed(54'h8000_0000);
        r = t[53:32];
        if (r > imutcf_pkg::ANGLE_LIMIT)
            r = imutcf_pkg::ANGLE_LIMIT;
        else if (r < -imutcf_pkg::ANGLE_LIMIT)
            r = -imutcf_pkg::ANGLE_LIMIT;
    end

    assign res_valid = v3_reg;
    assign res = r[16:0];

endmodule

### rtl/imu_tilt_complementary_filter.sv
// A sample passes the input register, the 16 CORDIC cells, the 3 blend registers and the output register.
// One sample is in the cell chain and blend stages at a time; in_ready returns when its result is taken.
// The 16-cell CORDIC chain is followed by the multiply blend stages.
// A new sample is taken while a finished result still waits on the output.
// Reset (rst_n, async low): angles clear to 0, registers load their defaults.
`include "imu_tilt_complementary_filter_macros.svh"
module imu_tilt_complementary_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] tilt_xz,
    output logic signed [16:0] tilt_yz
);

    localparam int N = imutcf_pkg::CORDIC_STEPS;

    logic [16:0]        blend_reg;
    logic [15:0]        gain_reg;
    logic               busy_reg;
    logic               pre_v_reg;
    logic               out_valid_reg;
    logic signed [16:0] angle_xz_reg, angle_yz_reg;
    logic signed [15:0] gx_reg, gy_reg;
    logic               zx_reg, zy_reg;
    logic               accept, take, wr;
    logic               rv_xz, rv_yz;
    logic signed [16:0] res_xz, res_yz;

    logic              vx [0:N];
    logic              vy [0:N];
    imutcf_pkg::cord_t cx [0:N];
    imutcf_pkg::cord_t cy [0:N];

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == imutcf_pkg::REG_GAIN) ? {16'b0, gain_reg}
                                                       : {15'b0, blend_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= imutcf_pkg::BLEND_RESET;
            gain_reg <= imutcf_pkg::GAIN_RESET;
        end
        else if (wr)
        begin
            case (paddr[2])
                imutcf_pkg::REG_BLEND: blend_reg <= pwdata[16:0];
                imutcf_pkg::REG_GAIN: gain_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign in_ready = ~busy_reg;
    assign accept = in_valid & ~busy_reg;
    assign take = rv_xz & (~out_valid_reg | out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pre_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_xz_reg <= '0;
            angle_yz_reg <= '0;
        end
        else
        begin
            pre_v_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (take)
                busy_reg <= 1'b0;
            if (take)
            begin
                out_valid_reg <= 1'b1;
                angle_xz_reg <= res_xz;
                angle_yz_reg <= res_yz;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx[0] <= imutcf_pkg::cordic_init(accel_x, accel_z);
            cy[0] <= imutcf_pkg::cordic_init(accel_y, accel_z);
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            zx_reg <= (accel_x == 16'sd0) && (accel_z == 16'sd0);
            zy_reg <= (accel_y == 16'sd0) && (accel_z == 16'sd0);
        end
    end

    assign vx[0] = pre_v_reg;
    assign vy[0] = pre_v_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_chain
        imutcf_cordic_cell u_cx (
            .clk(clk), .rst_n(rst_n), .valid_in(vx[k]), .d_in(cx[k]),
            .step(5'(k)), .valid_out(vx[k+1]), .d_out(cx[k+1])
        );
        imutcf_cordic_cell u_cy (
            .clk(clk), .rst_n(rst_n), .valid_in(vy[k]), .d_in(cy[k]),
            .step(5'(k)), .valid_out(vy[k+1]), .d_out(cy[k+1])
        );
    end

    imutcf_blend u_bxz (
        .clk(clk), .rst_n(rst_n), .valid_in(vx[N]), .take(take),
        .acc(cx[N].z), .zero(zx_reg), .prev(angle_xz_reg), .gyro(gy_reg),
        .gain(gain_reg), .weight(blend_reg), .res_valid(rv_xz), .res(res_xz)
    );

    imutcf_blend u_byz (
        .clk(clk), .rst_n(rst_n), .valid_in(vy[N]), .take(take),
        .acc(cy[N].z), .zero(zy_reg), .prev(angle_yz_reg), .gyro(gx_reg),
        .gain(gain_reg), .weight(blend_reg), .res_valid(rv_yz), .res(res_yz)
    );

    assign out_valid = out_valid_reg;
    assign tilt_xz = angle_xz_reg;
    assign tilt_yz = angle_yz_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready)
    `ASSERT_IMPLIES(a_lanes_lockstep, clk, rst_n, 1'b1, rv_xz == rv_yz)
    `ASSERT_NEXT(a_angle_hold, clk, rst_n, !take, $stable(angle_xz_reg) && $stable(angle_yz_reg))
    `ASSERT_IMPLIES(a_range, clk, rst_n, out_valid_reg,
        tilt_xz <= 17'sd46080 && tilt_xz >= -17'sd46080)

endmodule
